// File: src/clpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Class-pattern line matcher package
// Shared widths, item types, mode codes and the case-folding function.
// ----------------------------------------------------------------------------
package clpm_pkg;

   localparam int MAX_POSITIONS   = 64;
   localparam int POS_W           = $clog2(MAX_POSITIONS);
   localparam int LEN_W           = 7;
   localparam int BYTE_W          = 8;
   localparam int NUM_ROWS        = 1 << BYTE_W;
   localparam int LINE_INDEX_BITS = 16;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CSR_ADDR_W-3:0] REG_PATTERN_LENGTH = '0;

   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_TEXT  = 2'd2,
      MODE_EOL   = 2'd3
   } clpm_mode_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [BYTE_W-1:0] byte_value;
      logic [POS_W-1:0]  position;
   } clpm_req_type;

   typedef struct packed {
      logic [15:0] line_index;
      logic        matched;
   } clpm_rsp_type;

   typedef struct packed {
      logic              wr_clear;
      logic              wr_add;
      logic              rd_en;
      logic              row_ok;
      logic [BYTE_W-1:0] row;
   } clpm_mem_ctl_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic row_ok;
   } clpm_act_ctl_type;

   function automatic logic [BYTE_W-1:0] clpm_fold(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = b;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         r = b - CHAR_UPPER_A + CHAR_LOWER_A;
      end
      return r;
   endfunction

endpackage

// File: src/class_pattern_line_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Class-pattern line matcher core
// Streams text bytes and reports, at each end of line, whether the line held
// a substring matching a pattern of case-insensitive character classes.
//
// The req channel carries one item per accepted cycle: clear a byte's class
// row, add a byte to a position's class, a text byte, or an end of line.
// Only an end-of-line item produces an rsp item, holding the line index and
// the match flag. Items enter at one per cycle while req_stall is low;
// each byte passes a decode register and a row of 64 cells, each cell
// holding one pattern position's class column and prefix bit, and hands
// its prefix bit to the next cell. The rsp register loads as an EOL leaves s2.
// While an rsp item is stalled, text and class items keep flowing; only a
// second end of line reaching the last stage holds the pipeline and raises
// req_stall. Reset clears the class table at once through per-row valid
// bits, the prefix state, the line counter, and sets the length to one.
// The csr port writes pattern_length at address 0 and must be used idle.
// ----------------------------------------------------------------------------
module class_pattern_line_matcher_core
   import clpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  clpm_req_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output clpm_rsp_type          rsp_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LEN_W-1:0]           len_ff;
   logic [POS_W-1:0]           last_idx;
   logic                       s1_valid_ff;
   clpm_mode_type              s1_mode_ff;
   logic [BYTE_W-1:0]          s1_row_ff;
   logic [POS_W-1:0]           s1_pos_ff;
   logic                       s2_valid_ff;
   clpm_mode_type              s2_mode_ff;
   logic                       s2_ok_ff;
   logic [NUM_ROWS-1:0]        row_ok_ff;
   logic                       found_ff;
   logic                       found_in;
   logic [LINE_INDEX_BITS-1:0] line_cnt_ff;
   logic                       rsp_valid_ff;
   clpm_rsp_type               rsp_item_ff;
   logic                       adv;
   logic                       s2_eol_go;
   logic                       csr_wr;
   clpm_mem_ctl_type           mem_ctl;
   clpm_act_ctl_type           act_ctl;
   logic [MAX_POSITIONS-1:0]   act_vec;
   logic [MAX_POSITIONS-1:0]   hit_vec;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       csr_paddr[CSR_ADDR_W-1:2] == REG_PATTERN_LENGTH;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_PATTERN_LENGTH) ?
                       CSR_DATA_W'(len_ff) : '0;

   always_comb begin
      if (len_ff == '0) begin
         last_idx = '0;
      end else if (len_ff > LEN_W'(MAX_POSITIONS)) begin
         last_idx = POS_W'(MAX_POSITIONS - 1);
      end else begin
         last_idx = POS_W'(len_ff - LEN_W'(1));
      end
   end

   assign s2_eol_go = adv && s2_valid_ff && s2_mode_ff == MODE_EOL;
   assign adv       = !(s2_valid_ff && s2_mode_ff == MODE_EOL && rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      mem_ctl.wr_clear = adv && s1_valid_ff && s1_mode_ff == MODE_CLEAR;
      mem_ctl.wr_add   = adv && s1_valid_ff && s1_mode_ff == MODE_ADD;
      mem_ctl.rd_en    = adv && s1_valid_ff;
      mem_ctl.row_ok   = row_ok_ff[s1_row_ff];
      mem_ctl.row      = s1_row_ff;
      act_ctl.shift    = adv && s2_valid_ff && s2_mode_ff == MODE_TEXT;
      act_ctl.clear    = s2_eol_go;
      act_ctl.row_ok   = s2_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_W'(1);
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         row_ok_ff    <= '0;
         found_ff     <= 1'b0;
         line_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            len_ff <= csr_pwdata[LEN_W-1:0];
         end
         if (adv) begin
            s1_valid_ff <= req_valid;
            s2_valid_ff <= s1_valid_ff;
         end
         if (mem_ctl.wr_clear || mem_ctl.wr_add) begin
            row_ok_ff[s1_row_ff] <= 1'b1;
         end
         found_ff <= found_in;
         if (s2_eol_go && line_cnt_ff != '1) begin
            line_cnt_ff <= line_cnt_ff + LINE_INDEX_BITS'(1);
         end
         rsp_valid_ff <= s2_eol_go || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mode_ff <= clpm_mode_type'(req_item.mode);
         s1_row_ff  <= clpm_fold(req_item.byte_value);
         s1_pos_ff  <= req_item.position;
         s2_mode_ff <= s1_mode_ff;
         s2_ok_ff   <= row_ok_ff[s1_row_ff];
      end
      if (s2_eol_go) begin
         rsp_item_ff.line_index <= 16'(line_cnt_ff);
         rsp_item_ff.matched    <= found_ff;
      end
   end

   always_comb begin
      found_in = found_ff;
      if (s2_eol_go) begin
         found_in = 1'b0;
      end else if (|hit_vec) begin
         found_in = 1'b1;
      end
   end

   for (genvar g = 0; g < MAX_POSITIONS; g++) begin : g_cell
      logic prev_act;
      if (g == 0) begin : g_head
         assign prev_act = 1'b1;
      end else begin : g_body
         assign prev_act = act_vec[g-1];
      end
      clpm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .mem_ctl  (mem_ctl),
         .act_ctl  (act_ctl),
         .sel      (s1_pos_ff == POS_W'(g)),
         .is_last  (last_idx == POS_W'(g)),
         .prev_act (prev_act),
         .act      (act_vec[g]),
         .hit      (hit_vec[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_eol_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      s2_eol_go |=> rsp_valid_ff)
      else $error("end of line did not produce a result item");

   a_eol_clears_state: assert property (@(posedge clock) disable iff (reset)
      s2_eol_go |=> (act_vec == '0 && !found_ff))
      else $error("prefix state not cleared after end of line");

   a_counter_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> line_cnt_ff >= $past(line_cnt_ff))
      else $error("line counter decreased");

   a_hold_only_on_eol: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s2_valid_ff && s2_mode_ff == MODE_EOL && rsp_valid_ff))
      else $error("pipeline held without a waiting end of line");

endmodule

// File: src/clpm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Class-pattern line matcher cell
// One pattern position: its class column over all byte rows and its prefix bit.
// ----------------------------------------------------------------------------
module clpm_cell
   import clpm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  clpm_mem_ctl_type mem_ctl,
   input  clpm_act_ctl_type act_ctl,
   input  logic             sel,
   input  logic             is_last,
   input  logic             prev_act,
   output logic             act,
   output logic             hit
);

   logic col_mem [NUM_ROWS];
   logic rd_ff;
   logic act_ff;
   logic act_in;
   logic act_new;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_clear || (mem_ctl.wr_add && !sel && !mem_ctl.row_ok)) begin
         col_mem[mem_ctl.row] <= 1'b0;
      end else if (mem_ctl.wr_add && sel) begin
         col_mem[mem_ctl.row] <= 1'b1;
      end
      if (mem_ctl.rd_en) begin
         rd_ff <= col_mem[mem_ctl.row];
      end
   end

   assign act_new = prev_act & rd_ff & act_ctl.row_ok;

   always_comb begin
      act_in = act_ff;
      if (act_ctl.clear) begin
         act_in = 1'b0;
      end else if (act_ctl.shift) begin
         act_in = act_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

   assign act = act_ff;
   assign hit = act_new & is_last & act_ctl.shift;

endmodule

// File: tb/tb_class_pattern_line_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Class-pattern line matcher testbench
// Drives text, class-table and end-of-line items into the matcher and checks
// every line result against a shift-and predictor kept inside the bench.
// Directed tests cover register access, case folding, length limits,
// mid-line length changes and empty classes. Random phases then load class
// patterns and stream lines with embedded matches, noise and random idling.
// A final run streams short lines back to back with no idling.
// ----------------------------------------------------------------------------
module tb_class_pattern_line_matcher_core;
   import clpm_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int BURST_ITEMS  = 200;
   localparam int DRAIN_CYCLES = 4;
   localparam int END_CYCLES   = 8;
   localparam logic [CSR_ADDR_W-1:0] LENGTH_ADDR = {REG_PATTERN_LENGTH, 2'b00};
   localparam logic [BYTE_W-1:0] CASE_OFFSET = CHAR_LOWER_A - CHAR_UPPER_A;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   clpm_req_type          req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   clpm_rsp_type          rsp_item;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [MAX_POSITIONS-1:0]   class_rows [NUM_ROWS];
   logic [MAX_POSITIONS-1:0]   prefix_bits;
   logic                       line_hit;
   logic [LINE_INDEX_BITS-1:0] line_count;
   logic [LEN_W-1:0]           length_reg;
   clpm_rsp_type               expected_lines [$];

   bit idle_enable;
   int items_sent;
   int error_count;
   int cycle_count;
   int stall_left;

   class_pattern_line_matcher_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < 100) begin
         $display("ERROR: %s: got 0x%0h, expected 0x%0h", what, got, want);
      end
      error_count++;
   endtask

   function automatic int pattern_span(input logic [LEN_W-1:0] len);
      if (len == 0) begin
         return 1;
      end
      if (len > MAX_POSITIONS) begin
         return MAX_POSITIONS;
      end
      return int'(len);
   endfunction

   function automatic void track_line_match(input clpm_req_type it);
      logic [BYTE_W-1:0] row;
      int                last;
      clpm_rsp_type      line_result;
      row = it.byte_value;
      if (row >= CHAR_UPPER_A && row <= CHAR_UPPER_Z) begin
         row = row + CASE_OFFSET;
      end
      case (it.mode)
         MODE_CLEAR: class_rows[row] = '0;
         MODE_ADD: class_rows[row][it.position] = 1'b1;
         MODE_TEXT: begin
            last = pattern_span(length_reg) - 1;
            prefix_bits = {prefix_bits[MAX_POSITIONS-2:0], 1'b1} & class_rows[row];
            if (prefix_bits[last]) begin
               line_hit = 1'b1;
            end
         end
         default: begin
            line_result.line_index = line_count;
            line_result.matched = line_hit;
            expected_lines.insert(expected_lines.size(), line_result);
            if (line_count != '1) begin
               line_count++;
            end
            prefix_bits = '0;
            line_hit = 1'b0;
         end
      endcase
   endfunction

   always @(posedge clock) begin : line_check
      clpm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lines.size() == 0) begin
            report_mismatch("line result with none pending", longint'(rsp_item), 64'd0);
         end else begin
            want = expected_lines.pop_front();
            if (rsp_item.line_index !== want.line_index) begin
               report_mismatch("line_index", longint'(rsp_item.line_index),
                               longint'(want.line_index));
            end
            if (rsp_item.matched !== want.matched) begin
               report_mismatch("matched", longint'(rsp_item.matched),
                               longint'(want.matched));
            end
         end
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(input clpm_mode_type mode, input logic [BYTE_W-1:0] value,
                            input logic [POS_W-1:0] pos);
      clpm_req_type it;
      it.mode = mode;
      it.byte_value = value;
      it.position = pos;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      track_line_match(it);
   endtask

   task automatic drain_lines();
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= LENGTH_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] readback;
      drain_lines();
      wdata = $urandom;
      wdata[LEN_W-1:0] = len;
      csr_access(1'b1, wdata, readback);
      length_reg = len;
      csr_access(1'b0, $urandom, readback);
      if (readback[LEN_W-1:0] !== length_reg) begin
         report_mismatch("pattern_length readback", longint'(readback[LEN_W-1:0]),
                         longint'(length_reg));
      end
   endtask

   function automatic logic [BYTE_W-1:0] vary_case(input logic [BYTE_W-1:0] letter);
      return $urandom_range(0, 1) ? letter - CASE_OFFSET : letter;
   endfunction

   task automatic test_register_access();
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b0, '0, readback);
      if (readback[LEN_W-1:0] !== length_reg) begin
         report_mismatch("pattern_length after reset", longint'(readback[LEN_W-1:0]),
                         longint'(length_reg));
      end
      write_length(7'd127);
      write_length(7'd0);
      write_length(7'd1);
   endtask

   task automatic test_case_folding();
      send_item(MODE_EOL, 8'h00, 6'd0);
      send_item(MODE_ADD, "A", 6'd0);
      send_item(MODE_TEXT, "a", 6'd63);
      send_item(MODE_EOL, 8'hFF, 6'd63);
      send_item(MODE_TEXT, "A", 6'd0);
      send_item(MODE_EOL, 8'h00, 6'd0);
      send_item(MODE_CLEAR, "A", 6'd0);
      send_item(MODE_TEXT, "a", 6'd0);
      send_item(MODE_EOL, 8'h00, 6'd0);
   endtask

   task automatic test_length_limits();
      write_length(7'd2);
      send_item(MODE_ADD, 8'h00, 6'd1);
      send_item(MODE_ADD, 8'hFF, 6'd63);
      send_item(MODE_ADD, "z", 6'd0);
      send_item(MODE_TEXT, "Z", 6'd0);
      // The line stays open across the length change.
      write_length(7'd127);
      send_item(MODE_TEXT, 8'h00, 6'd0);
      send_item(MODE_EOL, 8'h00, 6'd0);
      write_length(7'd0);
      send_item(MODE_TEXT, "z", 6'd0);
      send_item(MODE_EOL, 8'h00, 6'd0);
      send_item(MODE_TEXT, 8'hFF, 6'd0);
      send_item(MODE_EOL, 8'h00, 6'd0);
   endtask

   task automatic test_empty_class();
      write_length(7'd3);
      send_item(MODE_TEXT, "z", 6'd0);
      send_item(MODE_TEXT, 8'h00, 6'd0);
      send_item(MODE_TEXT, "z", 6'd0);
      send_item(MODE_EOL, 8'h00, 6'd0);
   endtask

   task automatic send_filler(input int count, input logic [BYTE_W-1:0] letters [4]);
      repeat (count) begin
         case ($urandom_range(0, 19))
            0: send_item(MODE_ADD, BYTE_W'($urandom_range(0, 255)),
                         POS_W'($urandom_range(0, 63)));
            1: send_item(MODE_CLEAR, BYTE_W'($urandom_range(0, 255)),
                         POS_W'($urandom_range(0, 63)));
            2, 3, 4, 5: send_item(MODE_TEXT, BYTE_W'($urandom_range(0, 255)),
                                  POS_W'($urandom_range(0, 63)));
            default: send_item(MODE_TEXT, vary_case(letters[2'($urandom_range(0, 3))]),
                               POS_W'($urandom_range(0, 63)));
         endcase
      end
   endtask

   task automatic test_random_lines();
      logic [BYTE_W-1:0] letters [4];
      logic [BYTE_W-1:0] members [MAX_POSITIONS];
      logic [LEN_W-1:0]  len;
      int                stop_at;
      int                span;
      int                lines;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         idle_enable = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 15))
            0: len = 7'd0;
            1: len = 7'd127;
            2: len = 7'd64;
            3: len = 7'd1;
            4: len = LEN_W'($urandom_range(0, 127));
            default: len = LEN_W'($urandom_range(2, 6));
         endcase
         write_length(len);
         span = pattern_span(len);
         foreach (letters[i]) begin
            letters[i] = CHAR_LOWER_A + BYTE_W'($urandom_range(0, 25));
            send_item(MODE_CLEAR, vary_case(letters[i]), POS_W'($urandom_range(0, 63)));
         end
         for (int p = 0; p < span; p++) begin
            members[p] = letters[2'($urandom_range(0, 3))];
            if ($urandom_range(0, 19) != 0) begin
               send_item(MODE_ADD, vary_case(members[p]), POS_W'(p));
            end
            if ($urandom_range(0, 2) == 0) begin
               send_item(MODE_ADD, vary_case(letters[2'($urandom_range(0, 3))]), POS_W'(p));
            end
         end
         lines = $urandom_range(2, 8);
         for (int n = 0; n < lines; n++) begin
            send_filler($urandom_range(0, 6), letters);
            if ($urandom_range(0, 1) == 1) begin
               for (int p = 0; p < span; p++) begin
                  send_item(MODE_TEXT, vary_case(members[p]), POS_W'($urandom_range(0, 63)));
               end
            end
            send_filler($urandom_range(0, 6), letters);
            // Sometimes the last line runs on into the next pattern load.
            if (n != lines - 1 || $urandom_range(0, 3) != 0) begin
               send_item(MODE_EOL, BYTE_W'($urandom_range(0, 255)),
                         POS_W'($urandom_range(0, 63)));
            end
         end
      end
   endtask

   task automatic test_back_to_back_lines();
      write_length(7'd2);
      send_item(MODE_CLEAR, "q", 6'd0);
      send_item(MODE_CLEAR, "r", 6'd0);
      send_item(MODE_ADD, "q", 6'd0);
      send_item(MODE_ADD, "R", 6'd1);
      repeat (BURST_ITEMS) begin
         case ($urandom_range(0, 4))
            0: send_item(MODE_EOL, BYTE_W'($urandom_range(0, 255)),
                         POS_W'($urandom_range(0, 63)));
            1: send_item(MODE_TEXT, vary_case("q"), POS_W'($urandom_range(0, 63)));
            2: send_item(MODE_TEXT, vary_case("r"), POS_W'($urandom_range(0, 63)));
            default: send_item(MODE_TEXT, BYTE_W'($urandom_range(0, 255)),
                               POS_W'($urandom_range(0, 63)));
         endcase
      end
      send_item(MODE_EOL, 8'h00, 6'd0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      foreach (class_rows[i]) begin
         class_rows[i] = '0;
      end
      prefix_bits = '0;
      line_hit = 1'b0;
      line_count = '0;
      length_reg = 7'd1;
      idle_enable = 1'b1;
      items_sent = 0;
      error_count = 0;
      cycle_count = 0;
      stall_left = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_case_folding();
      test_length_limits();
      test_empty_class();
      test_random_lines();
      idle_enable = 1'b0;
      test_back_to_back_lines();
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/clpm_pkg.sv
src/clpm_cell.sv
src/class_pattern_line_matcher_core.sv
tb/tb_class_pattern_line_matcher_core.sv
